@@ hw/rtl/ttt_pkg.sv @@
package ttt_pkg;

  localparam int EDGE_W  = 12;
  localparam int PROB_W  = 64;
  localparam int TOTAL_W = 40;
  localparam int CFG_IDX_W = 1;

  localparam logic [PROB_W-1:0] ONE_Q63 = 64'h8000_0000_0000_0000;
  localparam logic [EDGE_W-1:0] OBS_COUNT_RESET = 12'd2;
  localparam logic [PROB_W-1:0] ALPHA_LEVEL_RESET = 64'h0666_6666_6666_6666;

  localparam logic [CFG_IDX_W-1:0] CFG_OBS_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEVEL = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_OFFER = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [EDGE_W-1:0] entry_index;
    logic [PROB_W-1:0] entry_value;
    logic [EDGE_W-1:0] support;
  } item_t;

  typedef struct packed {
    logic               is_testable;
    logic               is_prunable;
    logic [TOTAL_W-1:0] testable_total;
    logic [PROB_W-1:0]  threshold;
    logic [EDGE_W-1:0]  lower_edge;
    logic [EDGE_W-1:0]  centre_edge;
    logic [EDGE_W-1:0]  upper_edge;
  } result_t;

  typedef enum logic [3:0] {
    DP_NOP        = 4'd0,
    DP_TAB_WRITE  = 4'd1,
    DP_LOAD_EDGES = 4'd2,
    DP_CLEAR      = 4'd3,
    DP_THR_START  = 4'd4,
    DP_OFFER      = 4'd5,
    DP_MUL0       = 4'd6,
    DP_MUL1       = 4'd7,
    DP_MUL2       = 4'd8,
    DP_MUL3       = 4'd9,
    DP_SUB_A      = 4'd10,
    DP_SUB_MOVE   = 4'd11,
    DP_THR_PICK   = 4'd12,
    DP_THR_ZERO   = 4'd13
  } dp_op_t;

  typedef enum logic [1:0] {
    TSEL_SUP  = 2'd0,
    TSEL_ONE  = 2'd1,
    TSEL_OLOW = 2'd2
  } tsel_t;

  typedef enum logic {
    HSEL_SUP  = 1'b0,
    HSEL_EDGE = 1'b1
  } hsel_t;

  typedef struct packed {
    dp_op_t op;
    tsel_t  tsel;
    hsel_t  hsel;
  } dp_ctrl_t;

  localparam dp_ctrl_t DP_IDLE_CTRL = '{op: DP_NOP, tsel: TSEL_SUP, hsel: HSEL_SUP};

  typedef struct packed {
    logic collapsed;
    logic testable;
    logic exceed;
    logic clr_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ hw/rtl/ttt_seq.sv @@
module ttt_seq import ttt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [1:0] opcode,
  input  dp_status_t status,
  output dp_ctrl_t   ctrl,
  output logic       emit,
  output logic       idle
);

  localparam int PC_W = 5;

  typedef enum logic [2:0] {
    COND_NEXT         = 3'd0,
    COND_ALWAYS       = 3'd1,
    COND_COLLAPSED    = 3'd2,
    COND_NOT_TESTABLE = 3'd3,
    COND_NOT_EXCEED   = 3'd4,
    COND_NOT_CLR_LAST = 3'd5
  } cond_t;

  typedef enum logic [1:0] {
    FIN_NONE  = 2'd0,
    FIN_EMIT  = 2'd1,
    FIN_QUIET = 2'd2
  } fin_t;

  typedef struct packed {
    dp_ctrl_t        dp;
    cond_t           cond;
    logic [PC_W-1:0] target;
    fin_t            fin;
  } ucode_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  localparam logic [PC_W-1:0] PC_FIN        = 5'd0;
  localparam logic [PC_W-1:0] PC_LOAD       = 5'd1;
  localparam logic [PC_W-1:0] PC_START      = 5'd2;
  localparam logic [PC_W-1:0] PC_START_CLR  = 5'd3;
  localparam logic [PC_W-1:0] PC_START_RD   = 5'd4;
  localparam logic [PC_W-1:0] PC_START_THR  = 5'd5;
  localparam logic [PC_W-1:0] PC_OFFER      = 5'd6;
  localparam logic [PC_W-1:0] PC_OFFER_UPD  = 5'd7;
  localparam logic [PC_W-1:0] PC_LOOP       = 5'd8;
  localparam logic [PC_W-1:0] PC_MUL1       = 5'd9;
  localparam logic [PC_W-1:0] PC_MUL2       = 5'd10;
  localparam logic [PC_W-1:0] PC_MUL3       = 5'd11;
  localparam logic [PC_W-1:0] PC_TEST       = 5'd12;
  localparam logic [PC_W-1:0] PC_SUB_A      = 5'd13;
  localparam logic [PC_W-1:0] PC_SUB_MOVE   = 5'd14;
  localparam logic [PC_W-1:0] PC_RD_EDGES   = 5'd15;
  localparam logic [PC_W-1:0] PC_PICK       = 5'd16;
  localparam logic [PC_W-1:0] PC_ZERO       = 5'd17;
  localparam logic [PC_W-1:0] PC_RESET_CLR  = 5'd18;
  localparam logic [PC_W-1:0] PC_RESET_END  = 5'd19;
  localparam logic [PC_W-1:0] PC_LAST       = PC_RESET_END;

  function automatic ucode_t mk(input dp_op_t op, input tsel_t ts, input hsel_t hs,
                                input cond_t cd, input logic [PC_W-1:0] tg,
                                input fin_t fn);
    ucode_t w;
    w.dp.op   = op;
    w.dp.tsel = ts;
    w.dp.hsel = hs;
    w.cond    = cd;
    w.target  = tg;
    w.fin     = fn;
    return w;
  endfunction

  function automatic ucode_t rom(input logic [PC_W-1:0] a);
    ucode_t w;
    case (a)
      PC_FIN:       w = mk(DP_NOP, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_EMIT);
      PC_LOAD:      w = mk(DP_TAB_WRITE, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_EMIT);
      PC_START:     w = mk(DP_LOAD_EDGES, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_NONE);
      PC_START_CLR: w = mk(DP_CLEAR, TSEL_SUP, HSEL_SUP, COND_NOT_CLR_LAST, PC_START_CLR,
                           FIN_NONE);
      PC_START_RD:  w = mk(DP_NOP, TSEL_ONE, HSEL_SUP, COND_NEXT, PC_FIN, FIN_NONE);
      PC_START_THR: w = mk(DP_THR_START, TSEL_ONE, HSEL_SUP, COND_ALWAYS, PC_FIN, FIN_NONE);
      PC_OFFER:     w = mk(DP_NOP, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_NONE);
      PC_OFFER_UPD: w = mk(DP_OFFER, TSEL_SUP, HSEL_SUP, COND_NOT_TESTABLE, PC_FIN, FIN_NONE);
      PC_LOOP:      w = mk(DP_MUL0, TSEL_SUP, HSEL_SUP, COND_COLLAPSED, PC_FIN, FIN_NONE);
      PC_MUL1:      w = mk(DP_MUL1, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_NONE);
      PC_MUL2:      w = mk(DP_MUL2, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_NONE);
      PC_MUL3:      w = mk(DP_MUL3, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_NONE);
      PC_TEST:      w = mk(DP_NOP, TSEL_SUP, HSEL_EDGE, COND_NOT_EXCEED, PC_FIN, FIN_NONE);
      PC_SUB_A:     w = mk(DP_SUB_A, TSEL_SUP, HSEL_EDGE, COND_NEXT, PC_FIN, FIN_NONE);
      PC_SUB_MOVE:  w = mk(DP_SUB_MOVE, TSEL_SUP, HSEL_EDGE, COND_NEXT, PC_FIN, FIN_NONE);
      PC_RD_EDGES:  w = mk(DP_NOP, TSEL_OLOW, HSEL_SUP, COND_COLLAPSED, PC_ZERO, FIN_NONE);
      PC_PICK:      w = mk(DP_THR_PICK, TSEL_OLOW, HSEL_SUP, COND_ALWAYS, PC_LOOP, FIN_NONE);
      PC_ZERO:      w = mk(DP_THR_ZERO, TSEL_SUP, HSEL_SUP, COND_ALWAYS, PC_FIN, FIN_NONE);
      PC_RESET_CLR: w = mk(DP_CLEAR, TSEL_SUP, HSEL_SUP, COND_NOT_CLR_LAST, PC_RESET_CLR,
                           FIN_NONE);
      PC_RESET_END: w = mk(DP_NOP, TSEL_SUP, HSEL_SUP, COND_NEXT, PC_FIN, FIN_QUIET);
      default:      w = mk(DP_NOP, TSEL_SUP, HSEL_SUP, COND_ALWAYS, PC_FIN, FIN_NONE);
    endcase
    return w;
  endfunction

  seq_state_t      state;
  logic [PC_W-1:0] pc;
  ucode_t          word;
  logic            go;
  logic            jump;
  logic [PC_W-1:0] entry;

  assign word = rom(pc);
  assign idle = (state == S_IDLE);
  assign go   = (state == S_RUN) && !(word.fin == FIN_EMIT && !status.out_free);
  assign emit = go && (word.fin == FIN_EMIT);
  assign ctrl = go ? word.dp : DP_IDLE_CTRL;

  always_comb begin
    case (word.cond)
      COND_NEXT:         jump = 1'b0;
      COND_ALWAYS:       jump = 1'b1;
      COND_COLLAPSED:    jump = status.collapsed;
      COND_NOT_TESTABLE: jump = !status.testable;
      COND_NOT_EXCEED:   jump = !status.exceed;
      COND_NOT_CLR_LAST: jump = !status.clr_last;
      default:           jump = 1'b0;
    endcase
  end

  always_comb begin
    case (opcode)
      OP_LOAD:  entry = PC_LOAD;
      OP_START: entry = PC_START;
      OP_OFFER: entry = PC_OFFER;
      default:  entry = PC_FIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      pc    <= PC_RESET_CLR;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            pc    <= entry;
          end
        end
        S_RUN: begin
          if (go) begin
            if (word.fin != FIN_NONE) begin
              state <= S_IDLE;
            end else begin
              pc <= jump ? word.target : pc + PC_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_pc_bound: assert property (@(posedge clk) disable iff (rst) pc <= PC_LAST)
    else $error("sequencer step out of program");
  a_emit_free: assert property (@(posedge clk) disable iff (rst) emit |-> status.out_free)
    else $error("item emitted over a waiting result");
  a_reset_sweep: assert property (@(posedge clk) $past(rst) && !rst |-> state == S_RUN)
    else $error("clearing sweep not entered after reset");

endmodule

@@ hw/rtl/ttt_dpath.sv @@
module ttt_dpath import ttt_pkg::*; #(
  parameter int TABLE_DEPTH = 4096,
  parameter int COUNT_WIDTH = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  item_t             item,
  input  logic [EDGE_W-1:0] obs_count,
  input  logic [PROB_W-1:0] alpha_level,
  input  dp_ctrl_t          ctrl,
  input  logic              emit,
  output dp_status_t        status,
  output result_t           result,
  output logic              result_valid,
  input  logic              result_stall
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int EW = ((AW > EDGE_W) ? AW : EDGE_W) + 1;
  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [EW-1:0] DEPTH_E = EW'(TABLE_DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_DEPTH - 1);
  localparam logic [EDGE_W-1:0] RST_INNER_LOW  = OBS_COUNT_RESET >> 1;
  localparam logic [EDGE_W-1:0] RST_INNER_HIGH = OBS_COUNT_RESET - RST_INNER_LOW;
  localparam logic [EDGE_W-1:0] RST_OUTER_HIGH = OBS_COUNT_RESET - EDGE_W'(1);

  item_t             cur;
  logic [EDGE_W-1:0] outer_low, inner_low, inner_high, outer_high;
  logic              shrink_side;
  logic [CW-1:0]     count;
  logic [PROB_W-1:0] threshold;
  logic              testable_flag;
  logic [AW-1:0]     clr;
  logic [63:0]       pp;
  logic [127:0]      acc;

  logic [PROB_W-1:0] tab_mem [TABLE_DEPTH];
  logic [PROB_W-1:0] tab_q_a, tab_q_b;
  logic              tab_ok_a, tab_ok_b;
  logic [CW-1:0]     hist_mem [TABLE_DEPTH];
  logic [CW-1:0]     hist_q_a, hist_q_b;
  logic              hist_ok_a, hist_ok_b;

  logic [EDGE_W-1:0] tab_addr_a, hist_addr_a, hist_addr_b;
  logic [PROB_W-1:0] tab_a, tab_b;
  logic [CW-1:0]     hist_a, hist_b;
  logic              tab_we, hist_we;
  logic [AW-1:0]     hist_wa;
  logic [CW-1:0]     hist_wd;
  logic              collapsed, testable, exceed, differ;
  logic [63:0]       cnt64, product;
  logic [31:0]       mul_a, mul_b;
  logic [CW-1:0]     sub_val, sub_res;
  logic [EDGE_W-1:0] half;

  always_comb begin
    case (ctrl.tsel)
      TSEL_SUP:  tab_addr_a = cur.support;
      TSEL_ONE:  tab_addr_a = EDGE_W'(1);
      TSEL_OLOW: tab_addr_a = outer_low;
      default:   tab_addr_a = cur.support;
    endcase
  end

  assign hist_addr_a = (ctrl.hsel == HSEL_EDGE) ?
                       (shrink_side ? outer_low : inner_low) : cur.support;
  assign hist_addr_b = shrink_side ? outer_high : inner_high;

  assign tab_a  = tab_ok_a ? tab_q_a : ONE_Q63;
  assign tab_b  = tab_ok_b ? tab_q_b : ONE_Q63;
  assign hist_a = hist_ok_a ? hist_q_a : '0;
  assign hist_b = hist_ok_b ? hist_q_b : '0;

  assign collapsed = outer_low > inner_low;
  assign testable  = tab_a <= threshold;
  assign exceed    = (acc[127:64] != '0) || (pp != '0) || (acc[63:0] > alpha_level);
  assign differ    = shrink_side ? (outer_high != outer_low) : (inner_high != inner_low);

  assign tab_we = (ctrl.op == DP_TAB_WRITE) && (EW'(cur.entry_index) < DEPTH_E);

  always_comb begin
    hist_we = 1'b0;
    hist_wa = clr;
    hist_wd = '0;
    case (ctrl.op)
      DP_CLEAR: begin
        hist_we = 1'b1;
      end
      DP_OFFER: begin
        hist_we = testable && hist_ok_a && (hist_a != CNT_MAX);
        hist_wa = AW'(cur.support);
        hist_wd = hist_a + CW'(1);
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[AW'(cur.entry_index)] <= cur.entry_value;
    end
    tab_q_a  <= tab_mem[AW'(tab_addr_a)];
    tab_q_b  <= tab_mem[AW'(inner_low)];
    tab_ok_a <= EW'(tab_addr_a) < DEPTH_E;
    tab_ok_b <= EW'(inner_low) < DEPTH_E;
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_q_a  <= hist_mem[AW'(hist_addr_a)];
    hist_q_b  <= hist_mem[AW'(hist_addr_b)];
    hist_ok_a <= EW'(hist_addr_a) < DEPTH_E;
    hist_ok_b <= EW'(hist_addr_b) < DEPTH_E;
  end

  assign cnt64 = 64'(count);

  always_comb begin
    case (ctrl.op)
      DP_MUL0: begin
        mul_a = cnt64[31:0];
        mul_b = threshold[31:0];
      end
      DP_MUL1: begin
        mul_a = cnt64[31:0];
        mul_b = threshold[63:32];
      end
      DP_MUL2: begin
        mul_a = cnt64[63:32];
        mul_b = threshold[31:0];
      end
      default: begin
        mul_a = cnt64[63:32];
        mul_b = threshold[63:32];
      end
    endcase
  end

  assign product = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      DP_MUL0: begin
        pp <= product;
      end
      DP_MUL1: begin
        pp  <= product;
        acc <= {64'b0, pp};
      end
      DP_MUL2, DP_MUL3: begin
        pp  <= product;
        acc <= acc + ({64'b0, pp} << 32);
      end
      default: begin
        pp <= pp;
      end
    endcase
  end

  assign sub_val = (ctrl.op == DP_SUB_A) ? hist_a : hist_b;
  assign sub_res = (sub_val >= count) ? '0 : count - sub_val;
  assign half    = obs_count >> 1;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_low     <= EDGE_W'(1);
      inner_low     <= RST_INNER_LOW;
      inner_high    <= RST_INNER_HIGH;
      outer_high    <= RST_OUTER_HIGH;
      shrink_side   <= 1'b1;
      count         <= '0;
      threshold     <= '0;
      testable_flag <= 1'b0;
      clr           <= '0;
    end else begin
      if (accept) begin
        testable_flag <= 1'b0;
      end
      case (ctrl.op)
        DP_LOAD_EDGES: begin
          outer_low   <= EDGE_W'(1);
          inner_low   <= half;
          inner_high  <= obs_count - half;
          outer_high  <= (obs_count == '0) ? '0 : obs_count - EDGE_W'(1);
          shrink_side <= 1'b1;
          count       <= '0;
          clr         <= '0;
        end
        DP_CLEAR: begin
          clr <= clr + AW'(1);
        end
        DP_THR_START: begin
          threshold <= collapsed ? '0 : tab_a;
        end
        DP_OFFER: begin
          if (testable) begin
            testable_flag <= 1'b1;
            if (count != CNT_MAX) begin
              count <= count + CW'(1);
            end
          end
        end
        DP_SUB_A: begin
          count <= sub_res;
        end
        DP_SUB_MOVE: begin
          if (differ) begin
            count <= sub_res;
          end
          if (shrink_side) begin
            outer_low  <= outer_low + EDGE_W'(1);
            outer_high <= outer_high - EDGE_W'(1);
          end else begin
            inner_low  <= inner_low - EDGE_W'(1);
            inner_high <= inner_high + EDGE_W'(1);
          end
        end
        DP_THR_PICK: begin
          if (tab_a >= tab_b) begin
            threshold   <= tab_a;
            shrink_side <= 1'b1;
          end else begin
            threshold   <= tab_b;
            shrink_side <= 1'b0;
          end
        end
        DP_THR_ZERO: begin
          threshold <= '0;
        end
        default: begin
          clr <= clr;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.is_testable    <= testable_flag;
      result.is_prunable    <= (cur.opcode == OP_OFFER) && (cur.support > outer_high);
      result.testable_total <= TOTAL_W'(count);
      result.threshold      <= threshold;
      result.lower_edge     <= outer_low;
      result.centre_edge    <= inner_low;
      result.upper_edge     <= outer_high;
    end
  end

  assign status.collapsed = collapsed;
  assign status.testable  = testable;
  assign status.exceed    = exceed;
  assign status.clr_last  = (clr == CLR_LAST);
  assign status.out_free  = !result_valid || !result_stall;

  a_edge_gap: assert property (@(posedge clk) disable iff (rst)
      collapsed |-> outer_low == inner_low + EDGE_W'(1))
    else $error("region edges crossed by more than one");
  a_collapsed_zero: assert property (@(posedge clk) disable iff (rst)
      result_valid && (result.lower_edge > result.centre_edge) |-> result.threshold == '0)
    else $error("collapsed region reported with non-zero threshold");
  a_side_change: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) && (shrink_side != $past(shrink_side)) |->
      ($past(ctrl.op) == DP_THR_PICK || $past(ctrl.op) == DP_LOAD_EDGES))
    else $error("shrink side changed outside threshold pick");

endmodule

@@ hw/rtl/tarone_testability_threshold_core.sv @@
// channel  direction  handshake                  payload
// item     in         item_valid / item_stall    item_t (opcode, index, value, support)
// result   out        result_valid / result_stall result_t (flags, total, threshold, edges)
// cfg      in         cfg_write_en               cfg_index, cfg_data
//
// Load item: written to the table and emitted; unknown item: emitted. Offer item: ends
// after the histogram update when not testable, else shrinks the region until count times
// threshold no longer exceeds alpha or the region collapses. Start item: loads the edges,
// clears the histogram in a one-bucket-a-cycle sweep, then reads the starting threshold.
// Items are taken only while idle. After reset a clearing sweep runs before the first item.
// A waiting result does not block acceptance; the next item only stalls at its end.
module tarone_testability_threshold_core import ttt_pkg::*; #(
  parameter int TABLE_DEPTH = 4096,
  parameter int COUNT_WIDTH = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PROB_W-1:0]    cfg_data
);

  logic [EDGE_W-1:0] obs_count;
  logic [PROB_W-1:0] alpha_level;
  logic              accept;
  logic              idle;
  logic              emit;
  dp_ctrl_t          ctrl;
  dp_status_t        status;

  assign item_stall = !idle;
  assign accept     = item_valid && idle;

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_count   <= OBS_COUNT_RESET;
      alpha_level <= ALPHA_LEVEL_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_OBS_COUNT:   obs_count   <= cfg_data[EDGE_W-1:0];
        CFG_ALPHA_LEVEL: alpha_level <= cfg_data;
        default:         obs_count   <= obs_count;
      endcase
    end
  end

  ttt_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .opcode (item.opcode),
    .status (status),
    .ctrl   (ctrl),
    .emit   (emit),
    .idle   (idle)
  );

  ttt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (item),
    .obs_count    (obs_count),
    .alpha_level  (alpha_level),
    .ctrl         (ctrl),
    .emit         (emit),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

@@ bench/ttt_threshold_watch.sv @@
module ttt_threshold_watch import ttt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_stall,
  input  item_t                item,
  input  logic                 result_valid,
  input  logic                 result_stall,
  input  result_t              result,
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PROB_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   outstanding,
  output int                   testable_hits,
  output int                   shrink_steps
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1 << EDGE_W;
  localparam logic [TOTAL_W-1:0] TALLY_MAX = '1;
  localparam int REPORT_CAP = 40;

  logic [PROB_W-1:0]  pvalue_floor [DEPTH];
  logic [TOTAL_W-1:0] support_tally [DEPTH];
  logic [EDGE_W-1:0]  obs_setting;
  logic [PROB_W-1:0]  alpha_setting;
  logic [EDGE_W-1:0]  region_lo, centre_lo, centre_hi, region_hi;
  logic               trim_outer;
  logic [TOTAL_W-1:0] tally_total;
  logic [PROB_W-1:0]  level;
  result_t            threshold_reports [$];

  function automatic logic [TOTAL_W-1:0] drop_count(input logic [TOTAL_W-1:0] total,
                                                    input logic [TOTAL_W-1:0] amount);
    return (amount >= total) ? '0 : total - amount;
  endfunction

  function automatic logic over_budget(input logic [TOTAL_W-1:0] n,
                                       input logic [PROB_W-1:0] p,
                                       input logic [PROB_W-1:0] a);
    logic [127:0] prod;
    prod = 128'(n) * 128'(p);
    return prod > 128'(a);
  endfunction

  function automatic void restart_region();
    region_lo   = EDGE_W'(1);
    centre_lo   = obs_setting >> 1;
    centre_hi   = obs_setting - centre_lo;
    region_hi   = (obs_setting == 0) ? '0 : obs_setting - 1'b1;
    trim_outer  = 1'b1;
    tally_total = '0;
  endfunction

  function automatic void trim_region();
    if (trim_outer) begin
      tally_total = drop_count(tally_total, support_tally[region_lo]);
      if (region_hi != region_lo) begin
        tally_total = drop_count(tally_total, support_tally[region_hi]);
      end
      region_lo++;
      region_hi--;
    end else begin
      tally_total = drop_count(tally_total, support_tally[centre_lo]);
      if (centre_hi != centre_lo) begin
        tally_total = drop_count(tally_total, support_tally[centre_hi]);
      end
      centre_lo--;
      centre_hi++;
    end
    // zero if collapsed, else the larger edge value (outer on a tie) is the threshold; that side trims next
    if (region_lo > centre_lo) begin
      level = '0;
    end else if (pvalue_floor[region_lo] >= pvalue_floor[centre_lo]) begin
      level      = pvalue_floor[region_lo];
      trim_outer = 1'b1;
    end else begin
      level      = pvalue_floor[centre_lo];
      trim_outer = 1'b0;
    end
  endfunction

  function automatic result_t track_threshold(input item_t it);
    result_t r;
    r = '0;
    case (it.opcode)
      OP_LOAD: begin
        pvalue_floor[it.entry_index] = it.entry_value;
      end
      OP_START: begin
        foreach (support_tally[i]) support_tally[i] = '0;
        restart_region();
        level = (region_lo > centre_lo) ? '0 : pvalue_floor[1];
      end
      OP_OFFER: begin
        if (pvalue_floor[it.support] <= level) begin
          r.is_testable = 1'b1;
          testable_hits++;
          if (support_tally[it.support] != TALLY_MAX) begin
            support_tally[it.support]++;
          end
          if (tally_total != TALLY_MAX) tally_total++;
          while (!(region_lo > centre_lo) && over_budget(tally_total, level, alpha_setting)) begin
            trim_region();
            shrink_steps++;
          end
        end
        r.is_prunable = it.support > region_hi;
      end
      default: ;
    endcase
    r.testable_total = tally_total;
    r.threshold      = level;
    r.lower_edge     = region_lo;
    r.centre_edge    = centre_lo;
    r.upper_edge     = region_hi;
    return r;
  endfunction

  function automatic void check_field(input string label, input logic [PROB_W-1:0] want,
                                      input logic [PROB_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (pvalue_floor[i]) begin
        pvalue_floor[i]  = '0;
        support_tally[i] = '0;
      end
      obs_setting   = OBS_COUNT_RESET;
      alpha_setting = ALPHA_LEVEL_RESET;
      restart_region();
      level = '0;
      threshold_reports.delete();
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == CFG_OBS_COUNT) begin
          obs_setting = cfg_data[EDGE_W-1:0];
        end else if (cfg_index == CFG_ALPHA_LEVEL) begin
          alpha_setting = cfg_data;
        end
      end
      if (result_valid && !result_stall) begin
        if (threshold_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_CAP) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, result);
          end
        end else begin
          want = threshold_reports.pop_front();
          check_field("is_testable", PROB_W'(want.is_testable), PROB_W'(result.is_testable));
          check_field("is_prunable", PROB_W'(want.is_prunable), PROB_W'(result.is_prunable));
          check_field("testable_total", PROB_W'(want.testable_total),
                      PROB_W'(result.testable_total));
          check_field("threshold", want.threshold, result.threshold);
          check_field("lower_edge", PROB_W'(want.lower_edge), PROB_W'(result.lower_edge));
          check_field("centre_edge", PROB_W'(want.centre_edge), PROB_W'(result.centre_edge));
          check_field("upper_edge", PROB_W'(want.upper_edge), PROB_W'(result.upper_edge));
        end
      end
      if (item_valid && !item_stall) begin
        threshold_reports.push_back(track_threshold(item));
      end
    end
    outstanding <= threshold_reports.size();
  end

endmodule

@@ bench/tb_tarone_testability_threshold_core.sv @@
module tb_tarone_testability_threshold_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ttt_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int DEPTH = 1 << EDGE_W;
  localparam int FILL_TOP = 255;
  localparam longint RUN_LIMIT_NS = 64'd50_000_000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PROB_W-1:0]    cfg_data = '0;

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int reg_writes = 0;
  int mismatches, outstanding, testable_hits, shrink_steps;

  tarone_testability_threshold_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ttt_threshold_watch i_watch (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .testable_hits (testable_hits),
    .shrink_steps  (shrink_steps)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic item_t compose(input logic [1:0] op, input logic [EDGE_W-1:0] idx,
                                    input logic [PROB_W-1:0] val,
                                    input logic [EDGE_W-1:0] sup);
    item_t it;
    it.opcode      = op;
    it.entry_index = idx;
    it.entry_value = val;
    it.support     = sup;
    return it;
  endfunction

  // roughly symmetric about n/2, falling towards the centre, with local noise
  function automatic logic [PROB_W-1:0] shaped_floor(input int k, input int n);
    int reach;
    int shift;
    logic [PROB_W-1:0] v;
    reach = (k <= n - k) ? k : n - k;
    if (reach < 0) reach = 0;
    shift = reach / 2 + $urandom_range(3);
    if (shift > 63) shift = 63;
    v = ONE_Q63 >> shift;
    if ($urandom_range(1)) v = v - (v >> $urandom_range(4, 1));
    return v;
  endfunction

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 70; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 70; end
      default: begin sender_idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  task automatic send(input item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_obs(input int n);
    write_reg(CFG_OBS_COUNT, {$urandom, 20'($urandom), 12'(n)});
  endtask

  task automatic run_phase(input int n, input logic [PROB_W-1:0] alpha, input int count,
                           input int mode);
    int pick;
    int k;
    wait_drained();
    set_mode(mode);
    set_obs(n);
    write_reg(CFG_ALPHA_LEVEL, alpha);
    if (n <= 64) begin
      for (k = 0; k <= n; k++) begin
        send(compose(OP_LOAD, 12'(k), shaped_floor(k, n), 12'($urandom)));
      end
    end
    send(compose(OP_START, 12'($urandom), {$urandom, $urandom}, 12'($urandom)));
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        send(compose(OP_OFFER, 12'($urandom), {$urandom, $urandom},
                     12'($urandom_range(n, 0))));
      end else if (pick < 70) begin
        send(compose(OP_OFFER, 12'($urandom), {$urandom, $urandom},
                     12'($urandom_range(FILL_TOP))));
      end else if (pick < 80) begin
        k = $urandom_range(n, 0);
        send(compose(OP_LOAD, 12'(k), shaped_floor(k, n), 12'($urandom)));
      end else if (pick < 88) begin
        send(compose(OP_LOAD, 12'($urandom), {$urandom, $urandom}, 12'($urandom)));
      end else if (pick < 92) begin
        send(compose(OP_START, 12'($urandom), {$urandom, $urandom}, 12'($urandom)));
      end else if (pick < 95) begin
        send(compose(OP_SPARE, 12'($urandom), {$urandom, $urandom}, 12'($urandom)));
      end else begin
        send(compose(OP_OFFER, 12'($urandom), {$urandom, $urandom},
                     12'($urandom_range(n / 2 + 1, n / 2 > 0 ? n / 2 - 1 : 0))));
      end
      // now and then, hold off until everything in flight has come back
      if ($urandom_range(39) == 0) wait_drained();
    end
  endtask

  initial begin
    int p;
    int n;
    logic [PROB_W-1:0] alpha;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill every table entry that anything reads before it is read
    for (int k = 0; k <= FILL_TOP; k++) begin
      if (k % 32 == 0) set_mode(k / 32);
      send(compose(OP_LOAD, 12'(k), shaped_floor(k, FILL_TOP), 12'($urandom)));
    end
    send(compose(OP_LOAD, 12'(DEPTH - 1), ONE_Q63, 12'($urandom)));

    set_mode(0);
    send(compose(OP_OFFER, '0, '0, 12'd1));
    send(compose(OP_SPARE, '1, '1, '1));
    wait_drained();
    write_reg(CFG_ALPHA_LEVEL, ONE_Q63);
    send(compose(OP_START, '0, '0, '0));
    send(compose(OP_OFFER, '0, '0, 12'd1));
    send(compose(OP_OFFER, '1, '1, 12'd0));
    send(compose(OP_OFFER, '0, '0, 12'd4095));
    wait_drained();
    write_reg(CFG_ALPHA_LEVEL, '0);
    send(compose(OP_START, '1, '1, '1));
    send(compose(OP_OFFER, '0, '0, 12'd1));
    wait_drained();
    set_mode(3);
    set_obs(FILL_TOP);
    write_reg(CFG_ALPHA_LEVEL, ALPHA_LEVEL_RESET);
    send(compose(OP_START, '0, '0, '0));
    send(compose(OP_OFFER, '0, '0, 12'd1));
    send(compose(OP_OFFER, '0, '0, 12'(FILL_TOP / 2)));
    send(compose(OP_OFFER, '0, '0, 12'(FILL_TOP / 2 + 1)));
    send(compose(OP_OFFER, '0, '0, 12'(FILL_TOP - 1)));
    send(compose(OP_LOAD, 12'd4095, '1, '0));
    send(compose(OP_LOAD, 12'd0, '0, '1));
    send(compose(OP_OFFER, '0, '0, 12'd4095));
    send(compose(OP_OFFER, '0, '0, 12'd0));
    wait_drained();
    set_obs(1);
    send(compose(OP_START, '0, '0, '0));
    send(compose(OP_OFFER, '0, '0, 12'd0));
    wait_drained();
    set_obs(0);
    send(compose(OP_START, '0, '0, '0));
    send(compose(OP_OFFER, '0, '0, 12'd1));

    run_phase(2, ONE_Q63 >> 4, 30, 0);
    run_phase(FILL_TOP, ALPHA_LEVEL_RESET, 40, 1);
    for (p = 0; p < 10; p++) begin
      case (p % 3)
        0: n = $urandom_range(12, 3);
        1: n = $urandom_range(60, 13);
        default: n = $urandom_range(FILL_TOP, 100);
      endcase
      if (p == 4) alpha = '0;
      else if (p == 7) alpha = ONE_Q63;
      else alpha = ONE_Q63 >> $urandom_range(24, 1);
      run_phase(n, alpha, 40, p);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d items and %0d register writes across %0d idle/stall phases,",
             items_sent, reg_writes, 4);
    $display("with %0d testable offers and %0d region shrinks.", testable_hits, shrink_steps);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ttt_pkg.sv
hw/rtl/ttt_seq.sv
hw/rtl/ttt_dpath.sv
hw/rtl/tarone_testability_threshold_core.sv
bench/ttt_threshold_watch.sv
bench/tb_tarone_testability_threshold_core.sv
